@@ src/pmns_pkg.sv @@
// Shared types and constants for the PLL M/N/C parameter solver.
package pmns_pkg;

    localparam int REF_W      = 8;
    localparam int SEL_W      = 5;
    localparam int DES_W      = 10;
    localparam int NUM_W      = 14;
    localparam int DEN_W      = DES_W + 1;
    localparam int K_W        = 6;
    localparam int M_W        = 6;
    localparam int N_W        = 2;
    localparam int C_W        = 13;
    localparam int WORD_W     = 16;
    localparam int CWORD_W    = 23;
    localparam int CNT_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 80;
    localparam int M_TUSER_W  = 2;

    localparam logic [K_W-1:0]        K_FIRST     = 6'd12;
    localparam logic [K_W-1:0]        K_LAST      = 6'd60;
    localparam logic [CNT_W-1:0]      DIV_STEPS   = 4'd14;
    localparam logic [REF_W-1:0]      REF_RESET   = 8'd50;
    localparam logic [SEL_W-1:0]      SEL_RESET   = 5'd0;
    localparam logic [CFG_IDX_W-1:0]  IDX_REF     = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  IDX_SEL     = 1'd1;
    localparam logic [N_W-1:0]        N_ONE       = 2'd1;
    localparam logic [N_W-1:0]        N_TWO       = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic               done;
        logic [NUM_W-1:0]   quo;
        logic [DEN_W-1:0]   rem;
    } div_result_t;

endpackage

@@ src/pll_mnc_parameter_solver.sv @@
// Top level of the PLL M/N/C parameter solver: candidate sequencer and packing.
//
//  channel | dir | handshake                | payload
//  s_      | in  | s_tvalid / s_tready      | s_tdata: desired_freq
//  m_      | out | m_tvalid / m_tready      | m_tdata: M, N, C, words; m_tuser: flags
//  cfg_    | in  | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// A zero frequency skips the search; otherwise candidates are tried one after another,
// up to 49 of them (k = 12..60), stopping at the first exact one; the bit-serial
// divider works through each candidate in 14 steps.
// aresetn is synchronous; reset restores ref_freq 50 and counter_select 0.
// s_tready is high only while no item is in work; one finished result waits in
// the output register while the next item is taken and worked on.
module pll_mnc_parameter_solver
    import pmns_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [9:0] desired_freq
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [5:0] mult_m, [7:6] div_n, [20:8] post_c, [36:21] mult_word,
    // [52:37] div_word, [75:53] counter_word
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [M_TUSER_W-1:0]  m_tuser,   // [0] exact_hit, [1] c_zero
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    state_t state_reg, state_next;

    logic [REF_W-1:0] ref_freq_reg;
    logic [SEL_W-1:0] counter_select_reg;
    logic [DEN_W-1:0] den_reg,      den_next;
    logic [NUM_W-1:0] num_reg,      num_next;
    logic [K_W-1:0]   k_reg,        k_next;
    logic [K_W-1:0]   best_k_reg,   best_k_next;
    logic [C_W-1:0]   best_c_reg,   best_c_next;
    logic [DEN_W-1:0] best_rem_reg, best_rem_next;
    logic             exact_reg,    exact_next;

    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    logic        s_accept;
    logic        out_free;
    logic        div_start;
    div_result_t div_res;

    logic [DES_W-1:0] desired;
    logic [NUM_W-1:0] num_first;
    logic [M_W-1:0]   mult_m;
    logic [N_W-1:0]   div_n;
    logic [C_W-2:0]   c_hi;
    logic [C_W-2:0]   c_lo;
    logic [CWORD_W-1:0] counter_word;

    pmns_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_reg),
        .den     (den_reg),
        .result  (div_res)
    );

    assign desired   = s_tdata[DES_W-1:0];
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    // 12 * ref as 8 * ref + 4 * ref
    assign num_first = {3'b000, ref_freq_reg, 3'b000} + {4'b0000, ref_freq_reg, 2'b00};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = (desired == '0) ? ST_FINISH : ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_res.done) begin
                    if (div_res.rem == '0 || k_reg == K_LAST) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_tready  = 1'b1;
            ST_LOAD:   div_start = 1'b1;
            ST_WAIT:   ;
            ST_FINISH: ;
            default:   ;
        endcase
    end

    // candidate bookkeeping
    always_comb begin
        den_next      = den_reg;
        num_next      = num_reg;
        k_next        = k_reg;
        best_k_next   = best_k_reg;
        best_c_next   = best_c_reg;
        best_rem_next = best_rem_reg;
        exact_next    = exact_reg;
        if (state_reg == ST_IDLE && s_accept) begin
            den_next      = {desired, 1'b0};
            num_next      = num_first;
            k_next        = K_FIRST;
            best_k_next   = K_FIRST;
            best_c_next   = '0;
            best_rem_next = {desired, 1'b0};
            exact_next    = 1'b0;
        end else if (state_reg == ST_WAIT && div_res.done) begin
            if (div_res.rem == '0) begin
                best_k_next = k_reg;
                best_c_next = div_res.quo[C_W-1:0];
                exact_next  = 1'b1;
            end else if (div_res.rem < best_rem_reg) begin
                best_k_next   = k_reg;
                best_c_next   = div_res.quo[C_W-1:0];
                best_rem_next = div_res.rem;
            end
            // advance to the next candidate
            k_next   = k_reg + 1'b1;
            num_next = num_reg + {{(NUM_W-REF_W){1'b0}}, ref_freq_reg};
        end
    end

    // result packing
    always_comb begin
        if (best_k_reg[0]) begin
            mult_m = best_k_reg;
            div_n  = N_TWO;
        end else begin
            mult_m = {1'b0, best_k_reg[K_W-1:1]};
            div_n  = N_ONE;
        end
        c_hi         = best_c_reg[C_W-1:1];
        c_lo         = c_hi + {{(C_W-2){1'b0}}, best_c_reg[0]};
        counter_word = {counter_select_reg, 2'b00, c_hi[7:0], c_lo[7:0]};
    end

    always_comb begin
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (state_reg == ST_FINISH && out_free) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {4'b0000,
                             counter_word,
                             {6'b000000, div_n}, {6'b000000, div_n},
                             {2'b00, mult_m}, {2'b00, mult_m},
                             best_c_reg,
                             div_n,
                             mult_m};
            m_tuser_next  = {(best_c_reg == '0), exact_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            m_tvalid_reg       <= 1'b0;
            ref_freq_reg       <= REF_RESET;
            counter_select_reg <= SEL_RESET;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    IDX_REF: ref_freq_reg       <= cfg_data;
                    IDX_SEL: counter_select_reg <= cfg_data[SEL_W-1:0];
                    default: ;
                endcase
            end
        end
        den_reg      <= den_next;
        num_reg      <= num_next;
        k_reg        <= k_next;
        best_k_reg   <= best_k_next;
        best_c_reg   <= best_c_next;
        best_rem_reg <= best_rem_next;
        exact_reg    <= exact_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

endmodule

@@ src/pmns_divider.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
module pmns_divider
    import pmns_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output div_result_t       result
);

    logic [DEN_W-1:0] rem_reg,  rem_next;
    logic [NUM_W-1:0] quo_reg,  quo_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W:0]   diff;

    always_comb begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        fits  = (trial >= {1'b0, den});
        diff  = trial - {1'b0, den};
    end

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = num;
            cnt_next  = DIV_STEPS;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift one numerator bit into the partial remainder
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 4'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign result.done = done_reg;
    assign result.quo  = quo_reg;
    assign result.rem  = rem_reg;

endmodule

@@ src/pmns_checker.sv @@
// Port-level checks for the PLL M/N/C parameter solver, bound to the top level.
module pmns_checker
    import pmns_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic [M_TUSER_W-1:0]  m_tuser
);

    // one item in work at a time
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again right after a transaction");

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_n_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:6] == N_ONE && m_tdata[5:0] >= 6'd6 && m_tdata[5:0] <= 6'd30)
                  || (m_tdata[7:6] == N_TWO && m_tdata[0]))
        else $error("M and N do not come from one candidate");

    a_c_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[1] == (m_tdata[20:8] == 13'd0))
        else $error("c_zero flag disagrees with post_c");

    a_words: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[28:21] == {2'b00, m_tdata[5:0]}
                  && m_tdata[44:37] == {6'b000000, m_tdata[7:6]})
        else $error("packed words disagree with M or N");

endmodule

bind pll_mnc_parameter_solver pmns_checker u_pmns_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ tb/sv/pll_mnc_parameter_solver_tb.sv @@
// Self-checking testbench for the PLL M/N/C parameter solver.
`timescale 1ns / 1ps

module pll_mnc_parameter_solver_tb;
    import pmns_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 5;
    localparam int IDLE_PCT     = 27;
    localparam int STALL_LIMIT  = 20000;
    localparam int HOLD_AT      = 60;
    localparam int HOLD_CYCLES  = 3000;
    localparam int SOLVE_CYCLES = 800;
    localparam int RAND_PHASES  = 6;
    localparam int RAND_ITEMS   = 95;
    localparam int BYTE_MASK    = 8'hFF;
    localparam int SEL_MASK     = 5'h1F;
    localparam int ADDR_LSB     = 18;

    typedef struct packed {
        logic [M_W-1:0]     mult_m;
        logic [N_W-1:0]     div_n;
        logic [C_W-1:0]     post_c;
        logic               exact_hit;
        logic               c_zero;
        logic [WORD_W-1:0]  mult_word;
        logic [WORD_W-1:0]  div_word;
        logic [CWORD_W-1:0] counter_word;
    } solution_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = IDX_REF;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [DES_W-1:0]  desired_q[$];
    solution_t         solution_q[$];
    logic [REF_W-1:0]  cur_ref = REF_RESET;
    logic [SEL_W-1:0]  cur_sel = SEL_RESET;
    int unsigned       idle_pct = IDLE_PCT;
    int unsigned       errors = 0;
    int unsigned       results_seen = 0;
    int unsigned       hold_left = 0;
    int unsigned       stall_cycles = 0;

    pll_mnc_parameter_solver u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Search k = 12..60; first exact quotient wins, else smallest remainder.
    function automatic solution_t solve_pll(logic [DES_W-1:0] desired,
                                            logic [REF_W-1:0] refv,
                                            logic [SEL_W-1:0] sel);
        int unsigned den, num, q, r, best_rem, best_k, best_c, m, n, hi, lo;
        bit exact;
        solution_t s;
        best_k = K_FIRST;
        best_c = 0;
        exact  = 1'b0;
        if (desired != 0) begin
            den = 2 * desired;
            best_rem = den;
            for (int k = K_FIRST; k <= K_LAST; k++) begin
                num = k * refv;
                q = num / den;
                r = num % den;
                if (r == 0) begin
                    best_k = k;
                    best_c = q;
                    exact  = 1'b1;
                    break;
                end
                if (r < best_rem) begin
                    best_rem = r;
                    best_k = k;
                    best_c = q;
                end
            end
        end
        if (best_k[0] == 1'b0) begin
            m = best_k >> 1;
            n = N_ONE;
        end else begin
            m = best_k;
            n = N_TWO;
        end
        hi = best_c >> 1;
        lo = hi + (best_c & 1);
        s.mult_m       = M_W'(m);
        s.div_n        = N_W'(n);
        s.post_c       = C_W'(best_c);
        s.exact_hit    = exact;
        s.c_zero       = (best_c == 0);
        s.mult_word    = WORD_W'(((m & BYTE_MASK) << 8) | (m & BYTE_MASK));
        s.div_word     = WORD_W'(((n & BYTE_MASK) << 8) | (n & BYTE_MASK));
        s.counter_word = CWORD_W'(((sel & SEL_MASK) << ADDR_LSB)
                                  | ((hi & BYTE_MASK) << 8) | (lo & BYTE_MASK));
        return s;
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Request driver: predict at acceptance, then offer the next pending frequency.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                solution_q.push_back(solve_pll(s_tdata[DES_W-1:0], cur_ref, cur_sel));
            if (!s_tvalid || s_tready) begin
                if (desired_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'(desired_q.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random backpressure and one long hold-off.
    always @(posedge aclk) begin
        solution_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (solution_q.size() == 0) begin
                    $error("result transaction with no request outstanding");
                    errors++;
                end else begin
                    got = solution_q.pop_front();
                    check_field("mult_m", got.mult_m, m_tdata[5:0]);
                    check_field("div_n", got.div_n, m_tdata[7:6]);
                    check_field("post_c", got.post_c, m_tdata[20:8]);
                    check_field("mult_word", got.mult_word, m_tdata[36:21]);
                    check_field("div_word", got.div_word, m_tdata[52:37]);
                    check_field("counter_word", got.counter_word, m_tdata[75:53]);
                    check_field("exact_hit", got.exact_hit, m_tuser[0]);
                    check_field("c_zero", got.c_zero, m_tuser[1]);
                end
                results_seen++;
                if (results_seen == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == IDX_REF)
            cur_ref = data;
        else
            cur_sel = SEL_W'(data);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(logic [REF_W-1:0] refv, logic [SEL_W-1:0] sel);
        write_reg(IDX_REF, refv);
        write_reg(IDX_SEL, CFG_DATA_W'(sel));
    endtask

    // Hold until every request is sent and every result has come back.
    task automatic wait_drained(int unsigned extra);
        do @(posedge aclk);
        while (desired_q.size() != 0 || solution_q.size() != 0 || s_tvalid);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic push_random(int unsigned count);
        logic [DES_W-1:0] d;
        repeat (count) begin
            case ($urandom_range(0, 19))
                0:             d = '0;
                1, 2, 3, 4, 5: d = DES_W'($urandom_range(1, 63));
                default:       d = DES_W'($urandom_range(1, 1023));
            endcase
            desired_q.push_back(d);
        end
    endtask

    initial begin
        logic [REF_W-1:0] rv;
        logic [SEL_W-1:0] sv;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset configuration: zero request, extremes, exact and inexact cases.
        desired_q = {10'd0, 10'd1, 10'd1023, 10'd512, 10'd25, 10'd100, 10'd300,
                     10'd600, 10'd625, 10'd7, 10'd3, 10'd2, 10'd1000, 10'd683,
                     10'd341, 10'd170, 10'd85, 10'd42, 10'd21, 10'd10, 10'd5};
        wait_drained(4);

        // Zero reference: for each nonzero request k = 12 wins exactly with C = 0.
        set_config('0, 5'd31);
        desired_q = {10'd0, 10'd1, 10'd1023, 10'd777};
        wait_drained(4);

        set_config(8'd255, '0);
        desired_q = {10'd1, 10'd2, 10'd1023, 10'd0, 10'd17, 10'd255};
        wait_drained(4);

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       begin rv = 8'd1;   sv = 5'd31; end
                1:       begin rv = 8'd255; sv = 5'd16; end
                default: begin
                    rv = REF_W'($urandom_range(1, 255));
                    sv = SEL_W'($urandom_range(0, 31));
                end
            endcase
            set_config(rv, sv);
            // Run one phase with no idling on either side.
            idle_pct = (p == 3) ? 0 : IDLE_PCT;
            push_random(RAND_ITEMS);
            wait_drained(4);
        end

        wait_drained(SOLVE_CYCLES);
        if (solution_q.size() != 0)
            errors++;
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
